@@ rtl/core/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared codes, constants and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // command kinds
  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_PUT_AT = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  // port field widths
  localparam int unsigned COL_PORT_W = 7;
  localparam int unsigned ROW_PORT_W = 5;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CELL_W     = 16;

  // character codes
  localparam logic [BYTE_W-1:0] CH_ERROR   = 8'h45;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;

  // reset value of the default attribute
  localparam logic [BYTE_W-1:0] DEFAULT_ATTR_RST = 8'd15;

  // one finished transaction
  typedef struct packed {
    logic                  valid;
    logic [COL_PORT_W-1:0] cursor_col;
    logic [ROW_PORT_W-1:0] cursor_row;
    logic                  position_error;
    logic                  scrolled;
    logic [BYTE_W-1:0]     cell_character;
    logic [BYTE_W-1:0]     cell_attribute;
  } res_t;

endpackage

@@ rtl/core/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console with a cursor and a screen store.
// ----------------------------------------------------------------------------
// After reset the block sweeps the screen store to zero, one cell a cycle,
// with busy high. A put, a put at a given position, an error mark or an
// out-of-range read leaves busy low and its result is shown on the cycle
// after it is accepted. An in-range read holds busy for one cycle, since the
// store has registered read data, and its result is shown as busy falls. A
// clear walks every cell once, one cell a cycle, with busy high. A put that
// scrolls copies the lower COLS*(ROWS-1) cells one row up through the one
// read port and the one write port of the store, finishes the last
// write-back in a tail state and then zeroes the bottom row, with busy high
// throughout. The result of a clear or a scroll is shown as busy falls. Each
// result is shown for one cycle with done_o; the receiver cannot stall it,
// and a new command may be started while it is shown.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      kind_i,
  input  logic [tcw_pkg::BYTE_W-1:0]      character_i,
  input  logic [tcw_pkg::BYTE_W-1:0]      attribute_i,
  input  logic [tcw_pkg::COL_PORT_W-1:0]  col_i,
  input  logic [tcw_pkg::ROW_PORT_W-1:0]  row_i,
  input  logic                            cfg_we_i,
  input  logic [tcw_pkg::BYTE_W-1:0]      cfg_wdata_i,
  output logic                            done_o,
  output logic [tcw_pkg::COL_PORT_W-1:0]  cursor_col_o,
  output logic [tcw_pkg::ROW_PORT_W-1:0]  cursor_row_o,
  output logic                            position_error_o,
  output logic                            scrolled_o,
  output logic [tcw_pkg::BYTE_W-1:0]      cell_character_o,
  output logic [tcw_pkg::BYTE_W-1:0]      cell_attribute_o
);

  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);

  logic [tcw_pkg::BYTE_W-1:0] def_attr_q;
  tcw_pkg::res_t              res;
  tcw_pkg::res_t              res_q;
  logic                       done_q;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_rdata;

  // default attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_attr_q <= tcw_pkg::DEFAULT_ATTR_RST;
    end else if (cfg_we_i) begin
      def_attr_q <= cfg_wdata_i;
    end
  end

  tcw_seq #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .kind_i      (kind_i),
    .character_i (character_i),
    .attribute_i (attribute_i),
    .col_i       (col_i),
    .row_i       (row_i),
    .def_attr_i  (def_attr_q),
    .busy_o      (busy),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tcw_screen #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= res.valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      res_q <= res;
    end
  end

  assign done_o           = done_q;
  assign cursor_col_o     = res_q.cursor_col;
  assign cursor_row_o     = res_q.cursor_row;
  assign position_error_o = res_q.position_error;
  assign scrolled_o       = res_q.scrolled;
  assign cell_character_o = res_q.cell_character;
  assign cell_attribute_o = res_q.cell_attribute;

endmodule

@@ rtl/core/tcw_screen.sv @@
// ----------------------------------------------------------------------------
// tcw_screen
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_screen #(
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = 11
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [tcw_pkg::CELL_W-1:0]     wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr_i,
  output logic [tcw_pkg::CELL_W-1:0]     rdata_o
);

  logic [tcw_pkg::CELL_W-1:0] mem_q [DEPTH];
  logic [tcw_pkg::CELL_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tcw_seq.sv @@
// ----------------------------------------------------------------------------
// tcw_seq
// Command sequencer: cursor, cell writes, reads, scroll copy and fill sweeps.
// ----------------------------------------------------------------------------
module tcw_seq #(
  parameter int unsigned COLS = 80,
  parameter int unsigned ROWS = 25
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [1:0]                        kind_i,
  input  logic [tcw_pkg::BYTE_W-1:0]        character_i,
  input  logic [tcw_pkg::BYTE_W-1:0]        attribute_i,
  input  logic [tcw_pkg::COL_PORT_W-1:0]    col_i,
  input  logic [tcw_pkg::ROW_PORT_W-1:0]    row_i,
  input  logic [tcw_pkg::BYTE_W-1:0]        def_attr_i,
  output logic                              busy_o,
  output tcw_pkg::res_t                     res_o,
  output logic                              mem_we_o,
  output logic [$clog2(COLS*ROWS)-1:0]      mem_waddr_o,
  output logic [tcw_pkg::CELL_W-1:0]        mem_wdata_o,
  output logic                              mem_re_o,
  output logic [$clog2(COLS*ROWS)-1:0]      mem_raddr_o,
  input  logic [tcw_pkg::CELL_W-1:0]        mem_rdata_i
);

  localparam int unsigned CELLS = COLS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLS);
  localparam int unsigned RW    = $clog2(ROWS);

  localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_LAST  = AW'(CELLS - COLS - 1);
  localparam logic [AW-1:0] BOTTOM_ROW = AW'(CELLS - COLS);
  localparam logic [AW-1:0] ROW_STRIDE = AW'(COLS);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FILL   = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_TAIL   = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  logic [2:0]                   state_q, state_d;
  logic [AW-1:0]                idx_q, idx_d;
  logic [CW-1:0]                col_q, col_d;
  logic [RW-1:0]                row_q, row_d;
  logic [tcw_pkg::CELL_W-1:0]   fill_q, fill_d;
  logic                         init_q, init_d;
  logic                         scr_q, scr_d;
  logic                         wpend_q, wpend_d;
  logic [AW-1:0]                waddr_q, waddr_d;

  logic                         accept;
  logic                         in_range;
  logic [tcw_pkg::BYTE_W-1:0]   attr_eff;
  logic [CW-1:0]                put_col;
  logic [RW-1:0]                put_row;
  logic [AW-1:0]                put_addr;
  logic [AW-1:0]                tgt_addr;
  logic                         is_newline;
  logic                         wrap;
  logic [RW:0]                  next_row;
  logic                         need_scroll;
  logic [CW-1:0]                new_col;
  logic [RW-1:0]                new_row;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && (state_q == ST_IDLE);

  // decode of the incoming command
  assign in_range = ({1'b0, col_i} < (tcw_pkg::COL_PORT_W + 1)'(COLS)) &&
                    ({1'b0, row_i} < (tcw_pkg::ROW_PORT_W + 1)'(ROWS));
  assign attr_eff = (attribute_i == '0) ? def_attr_i : attribute_i;
  assign tgt_addr = AW'(RW'(row_i)) * ROW_STRIDE + AW'(CW'(col_i));

  // put position and cursor advance
  assign put_col     = (kind_i == tcw_pkg::KIND_PUT_AT) ? CW'(col_i) : col_q;
  assign put_row     = (kind_i == tcw_pkg::KIND_PUT_AT) ? RW'(row_i) : row_q;
  assign put_addr    = AW'(put_row) * ROW_STRIDE + AW'(put_col);
  assign is_newline  = (character_i == tcw_pkg::CH_NEWLINE);
  assign wrap        = (put_col == CW'(COLS - 1));
  assign next_row    = (is_newline || wrap) ? {1'b0, put_row} + (RW + 1)'(1)
                                            : {1'b0, put_row};
  assign need_scroll = (next_row == (RW + 1)'(ROWS));
  assign new_col     = (is_newline || wrap) ? '0 : put_col + CW'(1);
  assign new_row     = need_scroll ? RW'(ROWS - 1) : next_row[RW-1:0];

  // next state and memory port control
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    col_d       = col_q;
    row_d       = row_q;
    fill_d      = fill_q;
    init_d      = init_q;
    scr_d       = scr_q;
    wpend_d     = wpend_q;
    waddr_d     = waddr_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    res_o       = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            tcw_pkg::KIND_CLEAR: begin
              fill_d  = {def_attr_i, tcw_pkg::CH_SPACE};
              idx_d   = '0;
              col_d   = '0;
              row_d   = '0;
              scr_d   = 1'b0;
              state_d = ST_FILL;
            end
            tcw_pkg::KIND_READ: begin
              if (in_range) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = tgt_addr;
                state_d     = ST_READ;
              end else begin
                res_o.valid          = 1'b1;
                res_o.position_error = 1'b1;
              end
            end
            tcw_pkg::KIND_PUT, tcw_pkg::KIND_PUT_AT: begin
              if ((kind_i == tcw_pkg::KIND_PUT_AT) && !in_range) begin
                // error mark in the last cell, cursor stays
                mem_we_o             = 1'b1;
                mem_waddr_o          = LAST_CELL;
                mem_wdata_o          = {def_attr_i, tcw_pkg::CH_ERROR};
                res_o.valid          = 1'b1;
                res_o.position_error = 1'b1;
              end else begin
                if (!is_newline) begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = put_addr;
                  mem_wdata_o = {attr_eff, character_i};
                end
                col_d = new_col;
                row_d = new_row;
                if (need_scroll) begin
                  idx_d   = '0;
                  wpend_d = 1'b0;
                  scr_d   = 1'b1;
                  state_d = ST_SCROLL;
                end else begin
                  res_o.valid = 1'b1;
                end
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // copy each row up: read one row below, write it back in the following cycle
      ST_SCROLL: begin
        if (wpend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = waddr_q;
          mem_wdata_o = mem_rdata_i;
        end
        mem_re_o    = 1'b1;
        mem_raddr_o = idx_q + ROW_STRIDE;
        wpend_d     = 1'b1;
        waddr_d     = idx_q;
        if (idx_q == COPY_LAST) begin
          state_d = ST_TAIL;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      // last copied cell, then zero the bottom row
      ST_TAIL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = waddr_q;
        mem_wdata_o = mem_rdata_i;
        wpend_d     = 1'b0;
        idx_d       = BOTTOM_ROW;
        fill_d      = '0;
        state_d     = ST_FILL;
      end

      // sweep a constant cell value up to the last cell
      ST_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q;
        mem_wdata_o = fill_q;
        if (idx_q == LAST_CELL) begin
          state_d        = ST_IDLE;
          init_d         = 1'b0;
          res_o.valid    = !init_q;
          res_o.scrolled = scr_q;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end

      ST_READ: begin
        res_o.valid          = 1'b1;
        res_o.cell_character = mem_rdata_i[tcw_pkg::BYTE_W-1:0];
        res_o.cell_attribute = mem_rdata_i[tcw_pkg::CELL_W-1:tcw_pkg::BYTE_W];
        state_d              = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_o.cursor_col = tcw_pkg::COL_PORT_W'(col_d);
    res_o.cursor_row = tcw_pkg::ROW_PORT_W'(row_d);
  end

  // control registers; after reset the store is swept to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      idx_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      fill_q  <= '0;
      init_q  <= 1'b1;
      scr_q   <= 1'b0;
      wpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      col_q   <= col_d;
      row_q   <= row_d;
      fill_q  <= fill_d;
      init_q  <= init_d;
      scr_q   <= scr_d;
      wpend_q <= wpend_d;
    end
  end

  // pending write-back address of the scroll copy
  always_ff @(posedge clk_i) begin
    waddr_q <= waddr_d;
  end

  // cursor always inside the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_q} < (CW + 1)'(COLS)) && ({1'b0, row_q} < (RW + 1)'(ROWS)))
    else $error("cursor outside the screen");

  // a finished transaction always returns the sequencer to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> (state_q == ST_IDLE))
    else $error("result without return to idle");

  // no result during the reset sweep
  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> !res_o.valid)
    else $error("result during reset sweep");

  // scroll copy never reads and writes the same cell
  a_copy_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SCROLL) && wpend_q) |-> (mem_raddr_o != mem_waddr_o))
    else $error("scroll copy address clash");

  // the reset sweep only runs right after reset
  a_init_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_q |=> !init_q)
    else $error("reset sweep restarted");

endmodule

@@ tb/text_console_writer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking regression for the text console writer.
// ----------------------------------------------------------------------------
// A queue of pending steps (commands, default attribute writes and drains)
// is filled up front and fed to the block by a driver on the falling edge.
// A monitor on the rising edge keeps its own screen store, cursor and
// default attribute, predicts the status of every accepted command and
// checks each strobed result against the oldest prediction. Directed corner
// cases come first, then several random phases, each under its own default
// attribute, with random idle gaps and drains in between.
// ----------------------------------------------------------------------------
module text_console_writer_tb;

  localparam int unsigned COLS          = 80;
  localparam int unsigned ROWS          = 25;
  localparam int unsigned CELLS         = COLS * ROWS;
  localparam int unsigned RANDOM_PHASES = 5;
  localparam int unsigned PHASE_ITEMS   = 86;
  localparam int unsigned IDLE_LIMIT    = 20000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned REPORT_LIMIT  = 10;

  // kinds of pending step
  typedef enum logic [1:0] {
    STEP_CMD,
    STEP_CFG,
    STEP_DRAIN
  } step_e;

  typedef struct packed {
    tcw_pkg::kind_e                 kind;
    logic [tcw_pkg::BYTE_W-1:0]     character;
    logic [tcw_pkg::BYTE_W-1:0]     attribute;
    logic [tcw_pkg::COL_PORT_W-1:0] col;
    logic [tcw_pkg::ROW_PORT_W-1:0] row;
  } console_cmd_t;

  typedef struct packed {
    step_e                      step;
    console_cmd_t               cmd;
    logic [tcw_pkg::BYTE_W-1:0] cfg_value;
  } pending_step_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [1:0]                     kind_i;
  logic [tcw_pkg::BYTE_W-1:0]     character_i;
  logic [tcw_pkg::BYTE_W-1:0]     attribute_i;
  logic [tcw_pkg::COL_PORT_W-1:0] col_i;
  logic [tcw_pkg::ROW_PORT_W-1:0] row_i;
  logic                           cfg_we_i;
  logic [tcw_pkg::BYTE_W-1:0]     cfg_wdata_i;
  logic                           done_o;
  logic [tcw_pkg::COL_PORT_W-1:0] cursor_col_o;
  logic [tcw_pkg::ROW_PORT_W-1:0] cursor_row_o;
  logic                           position_error_o;
  logic                           scrolled_o;
  logic [tcw_pkg::BYTE_W-1:0]     cell_character_o;
  logic [tcw_pkg::BYTE_W-1:0]     cell_attribute_o;

  // stimulus and scoreboard state
  pending_step_t                  pending_q[$];
  tcw_pkg::res_t                  status_q[$];
  logic [tcw_pkg::CELL_W-1:0]     screen_model [0:CELLS-1];
  int unsigned                    cursor_model;
  logic [tcw_pkg::BYTE_W-1:0]     default_attr_model;
  logic                           last_fire;
  logic                           stim_done;
  int unsigned                    gap_left;
  int unsigned                    burst_left;
  int unsigned                    idle_cycles;
  int unsigned                    fail_count;
  logic [tcw_pkg::COL_PORT_W-1:0] last_put_col;
  logic [tcw_pkg::ROW_PORT_W-1:0] last_put_row;

  text_console_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .character_i     (character_i),
    .attribute_i     (attribute_i),
    .col_i           (col_i),
    .row_i           (row_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .cursor_col_o    (cursor_col_o),
    .cursor_row_o    (cursor_row_o),
    .position_error_o(position_error_o),
    .scrolled_o      (scrolled_o),
    .cell_character_o(cell_character_o),
    .cell_attribute_o(cell_attribute_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // status of one command, updating the screen and cursor copies
  function automatic tcw_pkg::res_t predict_console(console_cmd_t c);
    tcw_pkg::res_t              r;
    logic [tcw_pkg::BYTE_W-1:0] attr;
    logic                       in_range;
    int unsigned                pos;
    r          = '0;
    r.valid    = 1'b1;
    attr       = (c.attribute == '0) ? default_attr_model : c.attribute;
    in_range   = (int'(c.col) < COLS) && (int'(c.row) < ROWS);
    case (c.kind)
      tcw_pkg::KIND_CLEAR: begin
        for (int i = 0; i < CELLS; i++)
          screen_model[i] = {default_attr_model, tcw_pkg::CH_SPACE};
        cursor_model = 0;
      end
      tcw_pkg::KIND_READ: begin
        if (in_range) begin
          r.cell_character =
            screen_model[int'(c.row) * COLS + int'(c.col)][tcw_pkg::BYTE_W-1:0];
          r.cell_attribute =
            screen_model[int'(c.row) * COLS + int'(c.col)][tcw_pkg::CELL_W-1:tcw_pkg::BYTE_W];
        end else begin
          r.position_error = 1'b1;
        end
      end
      default: begin
        if (c.kind == tcw_pkg::KIND_PUT_AT && !in_range) begin
          // error mark in the last cell, cursor untouched
          screen_model[CELLS-1] = {default_attr_model, tcw_pkg::CH_ERROR};
          r.position_error      = 1'b1;
        end else begin
          pos = (c.kind == tcw_pkg::KIND_PUT_AT) ? int'(c.row) * COLS + int'(c.col)
                                                 : cursor_model;
          if (pos >= CELLS) pos = 0;
          if (c.character == tcw_pkg::CH_NEWLINE) begin
            pos = (pos / COLS + 1) * COLS;
          end else begin
            screen_model[pos] = {attr, c.character};
            pos++;
          end
          // ran past the last cell: scroll up one row
          if (pos >= CELLS) begin
            for (int i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
            for (int i = CELLS - COLS; i < CELLS; i++) screen_model[i] = '0;
            pos -= COLS;
            r.scrolled = 1'b1;
          end
          cursor_model = pos;
        end
      end
    endcase
    r.cursor_col = tcw_pkg::COL_PORT_W'(cursor_model % COLS);
    r.cursor_row = tcw_pkg::ROW_PORT_W'(cursor_model / COLS);
    return r;
  endfunction

  // idle gap after a transaction: mostly short, a few long, some bursts
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (roll < 3) begin
      burst_left = $urandom_range(60, 20);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 98) return $urandom_range(20, 4);
    return $urandom_range(300, 50);
  endfunction

  function automatic console_cmd_t make_cmd(tcw_pkg::kind_e kind,
                                            logic [tcw_pkg::BYTE_W-1:0] ch,
                                            logic [tcw_pkg::BYTE_W-1:0] attr,
                                            logic [tcw_pkg::COL_PORT_W-1:0] col,
                                            logic [tcw_pkg::ROW_PORT_W-1:0] row);
    console_cmd_t c;
    c.kind      = kind;
    c.character = ch;
    c.attribute = attr;
    c.col       = col;
    c.row       = row;
    return c;
  endfunction

  // push the column or the row past the edge of the screen
  function automatic console_cmd_t off_screen(console_cmd_t c);
    console_cmd_t o;
    o = c;
    if ($urandom_range(1) == 1)
      o.col = tcw_pkg::COL_PORT_W'(COLS + $urandom_range(127 - COLS));
    else
      o.row = tcw_pkg::ROW_PORT_W'(ROWS + $urandom_range(31 - ROWS));
    return o;
  endfunction

  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int unsigned  roll;
    c.kind      = tcw_pkg::KIND_PUT;
    c.character = tcw_pkg::BYTE_W'($urandom);
    c.attribute = ($urandom_range(4) == 0) ? '0 : tcw_pkg::BYTE_W'($urandom);
    c.col       = tcw_pkg::COL_PORT_W'($urandom);
    c.row       = tcw_pkg::ROW_PORT_W'($urandom);
    roll        = $urandom_range(99);
    if (roll < 3) begin
      c.kind = tcw_pkg::KIND_CLEAR;
    end else if (roll < 48) begin
      if ($urandom_range(9) == 0) c.character = tcw_pkg::CH_NEWLINE;
    end else if (roll < 73) begin
      c.kind = tcw_pkg::KIND_PUT_AT;
      if ($urandom_range(99) < 12) begin
        c = off_screen(c);
      end else begin
        // lean on the bottom row so that scrolls come often
        c.col = tcw_pkg::COL_PORT_W'($urandom_range(COLS - 1));
        c.row = ($urandom_range(4) == 0) ? tcw_pkg::ROW_PORT_W'(ROWS - 1)
                                         : tcw_pkg::ROW_PORT_W'($urandom_range(ROWS - 1));
        if ($urandom_range(9) == 0) c.character = tcw_pkg::CH_NEWLINE;
        last_put_col = c.col;
        last_put_row = c.row;
      end
    end else begin
      c.kind = tcw_pkg::KIND_READ;
      roll   = $urandom_range(99);
      if (roll < 10) begin
        c = off_screen(c);
      end else if (roll < 45) begin
        c.col = last_put_col;
        c.row = last_put_row;
      end else begin
        c.col = tcw_pkg::COL_PORT_W'($urandom_range(COLS - 1));
        c.row = tcw_pkg::ROW_PORT_W'($urandom_range(ROWS - 1));
      end
    end
    return c;
  endfunction

  task automatic queue_cmd(console_cmd_t c);
    pending_step_t s;
    s           = '0;
    s.step      = STEP_CMD;
    s.cmd       = c;
    pending_q.push_back(s);
  endtask

  task automatic queue_step(step_e step, logic [tcw_pkg::BYTE_W-1:0] value);
    pending_step_t s;
    s           = '0;
    s.step      = step;
    s.cfg_value = value;
    pending_q.push_back(s);
  endtask

  // driver: inputs change on the falling edge
  always @(negedge clk_i) begin : driver
    logic          start_n;
    logic          we_n;
    pending_step_t head;
    start_n = start;
    we_n    = 1'b0;
    if (rst_ni && !(start && !last_fire)) begin
      start_n = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() == 0) begin
        stim_done = 1'b1;
      end else begin
        head = pending_q[0];
        case (head.step)
          STEP_CMD: begin
            kind_i      <= head.cmd.kind;
            character_i <= head.cmd.character;
            attribute_i <= head.cmd.attribute;
            col_i       <= head.cmd.col;
            row_i       <= head.cmd.row;
            start_n     = 1'b1;
            gap_left    = pick_gap();
            void'(pending_q.pop_front());
          end
          STEP_CFG: begin
            if (status_q.size() == 0) begin
              cfg_wdata_i <= head.cfg_value;
              we_n        = 1'b1;
              void'(pending_q.pop_front());
            end
          end
          default: begin
            if (status_q.size() == 0) void'(pending_q.pop_front());
          end
        endcase
      end
    end
    start    <= start_n;
    cfg_we_i <= we_n;
  end

  // monitor: sample on the rising edge, predict and check
  always @(posedge clk_i) begin : monitor
    tcw_pkg::res_t want;
    console_cmd_t  cmd;
    logic          bad;
    last_fire = 1'b0;
    if (rst_ni) begin
      if (done_o) begin
        if (status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result with no transaction outstanding", $realtime);
        end else begin
          want = status_q.pop_front();
          bad  = (cursor_col_o     != want.cursor_col)     ||
                 (cursor_row_o     != want.cursor_row)     ||
                 (position_error_o != want.position_error) ||
                 (scrolled_o       != want.scrolled)       ||
                 (cell_character_o != want.cell_character) ||
                 (cell_attribute_o != want.cell_attribute);
          if (bad) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("%0t: mismatch col/row/err/scr/ch/at exp %0d/%0d/%0d/%0d/%02h/%02h",
                       $realtime, want.cursor_col, want.cursor_row, want.position_error,
                       want.scrolled, want.cell_character, want.cell_attribute);
              $display("%0t: mismatch col/row/err/scr/ch/at got %0d/%0d/%0d/%0d/%02h/%02h",
                       $realtime, cursor_col_o, cursor_row_o, position_error_o,
                       scrolled_o, cell_character_o, cell_attribute_o);
            end
          end
        end
      end
      if (cfg_we_i) default_attr_model = cfg_wdata_i;
      if (start && !busy) begin
        last_fire = 1'b1;
        cmd       = make_cmd(tcw_pkg::kind_e'(kind_i), character_i, attribute_i,
                             col_i, row_i);
        status_q.push_back(predict_console(cmd));
      end
      if (done_o || last_fire) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // watchdog
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("text_console_writer regression: fail");
    $finish;
  end

  initial begin
    rst_ni             = 1'b0;
    start              = 1'b0;
    kind_i             = '0;
    character_i        = '0;
    attribute_i        = '0;
    col_i              = '0;
    row_i              = '0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    last_fire          = 1'b0;
    stim_done          = 1'b0;
    gap_left           = 0;
    burst_left         = 0;
    idle_cycles        = 0;
    fail_count         = 0;
    cursor_model       = 0;
    default_attr_model = tcw_pkg::DEFAULT_ATTR_RST;
    last_put_col       = '0;
    last_put_row       = '0;
    for (int i = 0; i < CELLS; i++) screen_model[i] = '0;

    // directed corner cases under the reset default attribute
    queue_cmd(make_cmd(tcw_pkg::KIND_READ,   8'h00, 8'h00, 7'd0,   5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT,    8'h41, 8'h00, 7'd0,   5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT,    8'h42, 8'hFF, 7'd127, 5'd31));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT,    8'h00, 8'h01, 7'd0,   5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT,    8'h1B, 8'h80, 7'd0,   5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT,    8'hFF, 8'h00, 7'd0,   5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT,    tcw_pkg::CH_NEWLINE, 8'h00, 7'd0, 5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_READ,   8'h00, 8'h00, 7'd0,   5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_READ,   8'h00, 8'h00, 7'd4,   5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT_AT, 8'h78, 8'h00, 7'd79,  5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT_AT, tcw_pkg::CH_NEWLINE, 8'h00, 7'd0, 5'd24));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT_AT, 8'h5A, 8'h5A, 7'd79,  5'd24));
    queue_cmd(make_cmd(tcw_pkg::KIND_READ,   8'h00, 8'h00, 7'd79,  5'd23));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT_AT, 8'h51, 8'h00, 7'd80,  5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_READ,   8'h00, 8'h00, 7'd79,  5'd24));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT_AT, 8'hAA, 8'h55, 7'd127, 5'd31));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT_AT, 8'h33, 8'h00, 7'd0,   5'd25));
    queue_cmd(make_cmd(tcw_pkg::KIND_READ,   8'h00, 8'h00, 7'd80,  5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_READ,   8'h00, 8'h00, 7'd127, 5'd31));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT_AT, tcw_pkg::CH_NEWLINE, 8'h00, 7'd0, 5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_CLEAR,  8'hFF, 8'h33, 7'd127, 5'd31));
    queue_cmd(make_cmd(tcw_pkg::KIND_READ,   8'h00, 8'h00, 7'd40,  5'd12));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT,    8'h71, 8'h00, 7'd0,   5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_READ,   8'h00, 8'h00, 7'd0,   5'd0));
    queue_cmd(make_cmd(tcw_pkg::KIND_PUT_AT, tcw_pkg::CH_NEWLINE, 8'h77, 7'd40, 5'd12));

    // random phases, each under a fresh default attribute
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      queue_step(STEP_DRAIN, '0);
      case (p)
        0:       queue_step(STEP_CFG, 8'd1);
        1:       queue_step(STEP_CFG, 8'd255);
        default: queue_step(STEP_CFG, tcw_pkg::BYTE_W'($urandom_range(254, 2)));
      endcase
      // clear first now and then, so reads see the new attribute
      if ($urandom_range(1) == 1)
        queue_cmd(make_cmd(tcw_pkg::KIND_CLEAR, 8'h00, 8'h00, 7'd0, 5'd0));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        queue_cmd(random_cmd());
        if ($urandom_range(49) == 0) queue_step(STEP_DRAIN, '0);
      end
    end

    // reset held low at the start, released on a falling edge
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (!stim_done || status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

endmodule
